// ===== hw/rtl/lmrs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LED matrix row scanner.
// No dependencies.
package lmrs_pkg;

    localparam int COL_W      = 6;
    localparam int PIX_W      = 3;
    localparam int ROWADDR_W  = 5;
    localparam int NUM_HALVES = 4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_DRAW  = 2'd1,
        OP_RESET = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [COL_W-1:0]   pixel_x;
        logic [6:0]         pixel_y;
        logic [PIX_W-1:0]   color;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]     column;
        logic [ROWADDR_W-1:0] row_address;
        logic [PIX_W-1:0]     panel0_upper;
        logic [PIX_W-1:0]     panel0_lower;
        logic [PIX_W-1:0]     panel1_upper;
        logic [PIX_W-1:0]     panel1_lower;
        logic                 latch_row;
    } t_out_item;

endpackage

// ===== hw/rtl/lmrs_in_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying pixel and control commands.
// Depends on lmrs_pkg.
interface lmrs_in_if;
    logic                valid;
    logic                ready;
    lmrs_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lmrs_out_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one column of scan data per transaction.
// Depends on lmrs_pkg.
interface lmrs_out_if;
    logic                valid;
    logic                ready;
    lmrs_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lmrs_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lmrs_ram #(
    parameter int WIDTH  = 12,
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/led_matrix_row_scanner.sv =====
`timescale 1ns / 1ps
// LED matrix row scanner top level: frame store, scan row and column output pipeline.
// Depends on lmrs_pkg, lmrs_in_if, lmrs_out_if and lmrs_ram.
//
// The frame store is one RAM word per (scan row, column) holding the four panel-half
// pixels side by side, so a draw reads all four pixels of a column in one access.
// A draw shifts out COLUMNS transactions, one per cycle while the output is ready, each
// passing through the RAM read register and the output register; the single RAM read
// port sets that rate. A pixel write is a read-modify-write of one word, written back in
// the S_WB state. A scan row reset returns the scan row to zero. After reset and after a
// clear command the block sweeps all 64 * 2**ceil(log2(HALF_ROWS)) RAM words (2048 at
// the defaults) writing zeros, and accepts no command until the sweep is done.
module led_matrix_row_scanner #(
    parameter int COLUMNS   = 64,
    parameter int HALF_ROWS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lmrs_in_if.sink      i_pix,
    lmrs_out_if.source   o_col
);

    localparam int ROW_W  = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
    localparam int ADDR_W = ROW_W + lmrs_pkg::COL_W;
    localparam int WORD_W = lmrs_pkg::NUM_HALVES * lmrs_pkg::PIX_W;

    localparam logic [8:0] HALF9  = 9'(HALF_ROWS);
    localparam logic [8:0] TWO9   = 9'(2 * HALF_ROWS);
    localparam logic [8:0] THREE9 = 9'(3 * HALF_ROWS);
    localparam logic [8:0] STORE9 = 9'(4 * HALF_ROWS);
    localparam logic [lmrs_pkg::COL_W:0]   COLS_LIM = (lmrs_pkg::COL_W + 1)'(COLUMNS);
    localparam logic [lmrs_pkg::COL_W-1:0] LAST_COL = lmrs_pkg::COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]           LAST_ROW = ROW_W'(HALF_ROWS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WB,
        S_DRAW
    } t_state;

    t_state                        r_state;
    logic [ADDR_W-1:0]             r_clr_addr;
    logic [ROW_W-1:0]              r_scan_row;
    logic [ROW_W-1:0]              r_draw_row;
    logic [lmrs_pkg::COL_W-1:0]    r_col;
    logic [ADDR_W-1:0]             r_wr_addr;
    logic [1:0]                    r_wr_half;
    logic [lmrs_pkg::PIX_W-1:0]    r_wr_color;
    logic                          r_s1_v;
    logic [lmrs_pkg::COL_W-1:0]    r_s1_col;
    logic                          r_s1_last;
    logic                          r_s2_v;
    lmrs_pkg::t_out_item           r_s2_item;

    logic [ROW_W-1:0]              n_scan_row;
    lmrs_pkg::t_out_item           n_s2_item;

    logic                          in_fire;
    lmrs_pkg::t_op                 op;
    logic [8:0]                    py9;
    logic [8:0]                    row9;
    logic [1:0]                    wr_half;
    logic                          wr_ok;
    logic                          wr_go;
    logic                          s1_move;
    logic                          draw_re;
    logic [ROW_W+lmrs_pkg::ROWADDR_W-1:0] row_ext;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [WORD_W-1:0]             ram_wdata;
    logic [WORD_W-1:0]             merged;
    logic                          ram_re;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [WORD_W-1:0]             ram_rdata;

    assign i_pix.ready = (r_state == S_IDLE) && !r_s1_v;
    assign in_fire     = i_pix.valid && i_pix.ready;
    assign op          = i_pix.payload.operation;

    // store row -> panel half and row within the half
    assign py9 = {2'b00, i_pix.payload.pixel_y};
    always_comb begin
        if (py9 >= THREE9) begin
            wr_half = 2'd3;
            row9    = py9 - THREE9;
        end else if (py9 >= TWO9) begin
            wr_half = 2'd2;
            row9    = py9 - TWO9;
        end else if (py9 >= HALF9) begin
            wr_half = 2'd1;
            row9    = py9 - HALF9;
        end else begin
            wr_half = 2'd0;
            row9    = py9;
        end
    end

    assign wr_ok = ({1'b0, i_pix.payload.pixel_x} < COLS_LIM) && (py9 < STORE9);
    assign wr_go = in_fire && (op == lmrs_pkg::OP_WRITE) && wr_ok;

    assign s1_move = r_s1_v && (!r_s2_v || o_col.ready);
    assign draw_re = (r_state == S_DRAW) && (!r_s1_v || s1_move);

    assign ram_re    = wr_go || draw_re;
    assign ram_raddr = wr_go ? {row9[ROW_W-1:0], i_pix.payload.pixel_x} : {r_draw_row, r_col};

    always_comb begin
        for (int i = 0; i < lmrs_pkg::NUM_HALVES; i++) begin
            merged[i*lmrs_pkg::PIX_W +: lmrs_pkg::PIX_W] =
                (r_wr_half == 2'(i)) ? r_wr_color
                                     : ram_rdata[i*lmrs_pkg::PIX_W +: lmrs_pkg::PIX_W];
        end
    end

    assign ram_we    = (r_state == S_WB) || (r_state == S_CLEAR);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_wr_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : merged;

    lmrs_ram #(
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign n_scan_row = (r_scan_row == LAST_ROW) ? '0 : ROW_W'(r_scan_row + 1'b1);
    assign row_ext    = {{lmrs_pkg::ROWADDR_W{1'b0}}, r_draw_row};

    always_comb begin
        n_s2_item.column       = r_s1_col;
        n_s2_item.row_address  = row_ext[lmrs_pkg::ROWADDR_W-1:0];
        n_s2_item.panel0_upper = ram_rdata[0*lmrs_pkg::PIX_W +: lmrs_pkg::PIX_W];
        n_s2_item.panel0_lower = ram_rdata[1*lmrs_pkg::PIX_W +: lmrs_pkg::PIX_W];
        n_s2_item.panel1_upper = ram_rdata[2*lmrs_pkg::PIX_W +: lmrs_pkg::PIX_W];
        n_s2_item.panel1_lower = ram_rdata[3*lmrs_pkg::PIX_W +: lmrs_pkg::PIX_W];
        n_s2_item.latch_row    = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_scan_row <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= ADDR_W'(r_clr_addr + 1'b1);
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        case (op)
                            lmrs_pkg::OP_WRITE: begin
                                if (wr_ok) begin
                                    r_wr_addr  <= ram_raddr;
                                    r_wr_half  <= wr_half;
                                    r_wr_color <= i_pix.payload.color;
                                    r_state    <= S_WB;
                                end
                            end
                            lmrs_pkg::OP_DRAW: begin
                                r_draw_row <= r_scan_row;
                                r_scan_row <= n_scan_row;
                                r_col      <= '0;
                                r_state    <= S_DRAW;
                            end
                            lmrs_pkg::OP_RESET: begin
                                r_scan_row <= '0;
                            end
                            lmrs_pkg::OP_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= S_CLEAR;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_WB: begin
                    r_state <= S_IDLE;
                end
                S_DRAW: begin
                    if (draw_re) begin
                        r_col <= lmrs_pkg::COL_W'(r_col + 1'b1);
                        if (r_col == LAST_COL) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // read stage: RAM output register holds while not re-read
            if (draw_re) begin
                r_s1_v    <= 1'b1;
                r_s1_col  <= r_col;
                r_s1_last <= (r_col == LAST_COL);
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end

            if (s1_move) begin
                r_s2_v    <= 1'b1;
                r_s2_item <= n_s2_item;
            end else if (o_col.ready) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    assign o_col.valid   = r_s2_v;
    assign o_col.payload = r_s2_item;

endmodule

// ===== hw/rtl/lmrs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the LED matrix row scanner, bound to the top level.
// Depends on lmrs_pkg and led_matrix_row_scanner.
module lmrs_checker #(
    parameter int COLUMNS = 64
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input lmrs_pkg::t_out_item i_out_item
);

    logic                          r_mid;
    logic [lmrs_pkg::COL_W-1:0]    r_exp_col;
    logic [lmrs_pkg::ROWADDR_W-1:0] r_row;
    logic                          out_fire;

    assign out_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid     <= 1'b0;
            r_exp_col <= '0;
            r_row     <= '0;
        end else if (out_fire) begin
            r_mid     <= !i_out_item.latch_row;
            r_exp_col <= i_out_item.latch_row ? '0
                                              : lmrs_pkg::COL_W'(i_out_item.column + 1'b1);
            r_row     <= i_out_item.row_address;
        end
    end

    // stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("output transaction changed while stalled");

    // columns come out in order and the latch lands on the last one
    a_col_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_item.column == r_exp_col) &&
                        (i_out_item.latch_row == (i_out_item.column ==
                                                  lmrs_pkg::COL_W'(COLUMNS - 1))))
        else $error("column sequence or latch position wrong");

    // one row address across a draw
    a_row_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_mid |-> i_out_item.row_address == r_row)
        else $error("row address changed within a draw");

    // input not ready and output idle just after reset, as the frame clear starts
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ready && !i_out_valid)
        else $error("commands accepted before clear sweep");

endmodule

bind led_matrix_row_scanner lmrs_checker #(
    .COLUMNS (COLUMNS)
) u_lmrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_col.valid),
    .i_out_ready (o_col.ready),
    .i_out_item  (o_col.payload)
);
